// ===== rtl/core/pac_pkg.sv =====
`timescale 1ns / 1ps

package pac_pkg;

  localparam int DATA_W             = 16;
  localparam int PCT_W              = 7;
  localparam int CFG_IDX_W          = 2;
  localparam int WINDOW_LEN_DEFAULT = 4;

  localparam logic [PCT_W-1:0]  COVER_FULL_SCALE = 7'd100;
  localparam logic [DATA_W-1:0] THRESHOLD_RESET  = 16'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET     = 2'd0,
    CFG_FULL_COVER = 2'd1,
    CFG_THRESHOLD  = 2'd2
  } cfg_reg_t;

endpackage

// ===== rtl/core/pac_if.sv =====
`timescale 1ns / 1ps

interface pac_sample_if import pac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface pac_result_if import pac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] mean_value;
  logic              change_seen;
  logic [PCT_W-1:0]  cover_percent;

  modport source (output valid, output mean_value, output change_seen,
                  output cover_percent, input ready);
  modport sink   (input valid, input mean_value, input change_seen,
                  input cover_percent, output ready);
endinterface

// ===== rtl/core/proximity_average_cover.sv =====
`timescale 1ns / 1ps
// Proximity moving average with sticky change flag and cover estimate.
//
// sample_ch carries one raw reading per item; result_ch returns one item per
// reading: window mean, sticky change flag and cover percent (0..100).
// Registers are written through cfg_we / cfg_index / cfg_data, one per clock;
// an index past the last register is ignored.
//
// The window mean comes from a constant reciprocal multiply.
// The cover ratio runs through a restoring divider, one quotient bit per
// cycle. Each reading steps through the mean, the change check and offset
// correction, the saturation check, the divider (skipped when the cover
// saturates or the full-cover count is zero) and the output load; the next
// reading is taken only once the sequencer is back in idle.
//
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver still stalls when the next result is done, the
// sequencer holds in its last state until the output register frees.
// Reset (rst, synchronous) clears the window, the previous mean, the change
// flag and the registers (threshold to 30), and drops any pending result.
module proximity_average_cover import pac_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  pac_sample_if.sink           sample_ch,
  pac_result_if.source         result_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int SUM_W  = DATA_W + $clog2(WINDOW_LEN);
  localparam int PROD_W = DATA_W + PCT_W;
  localparam int CNT_W  = $clog2(PCT_W);

  // floor(sum / WINDOW_LEN) as (sum * RECIP) >> RECIP_SHIFT; RECIP is rounded
  // up, so the error stays below 1 / WINDOW_LEN for any sum below 2^SUM_W
  localparam int     RECIP_SHIFT = SUM_W + $clog2(WINDOW_LEN);
  localparam int     RECIP_W     = SUM_W + 1;
  localparam int     MPROD_W     = SUM_W + RECIP_W;
  localparam longint RECIP       =
    ((longint'(1) << RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MEAN_DONE,
    ST_SCALE,
    ST_COVER_DIV,
    ST_FINISH
  } state_t;

  state_t state;

  logic [DATA_W-1:0] offset_counts;
  logic [DATA_W-1:0] full_cover_counts;
  logic [DATA_W-1:0] change_threshold;

  logic [DATA_W-1:0] window [WINDOW_LEN];
  logic [SUM_W-1:0]  sum;
  logic [DATA_W-1:0] prev_mean;
  logic              change_latch;

  // divider registers, acc shared with the mean
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] den;
  logic [CNT_W-1:0]  cnt;

  logic [DATA_W-1:0] corrected;
  logic [PCT_W-1:0]  cover_val;

  logic              res_valid;
  logic [DATA_W-1:0] res_mean;
  logic              res_change;
  logic [PCT_W-1:0]  res_cover;

  logic [DATA_W+1:0]  trial;
  logic               qbit;
  logic [DATA_W-1:0]  rem_next;
  logic [DATA_W-1:0]  abs_diff;
  logic [PROD_W-1:0]  prod;
  logic [MPROD_W-1:0] mean_prod;

  always_comb begin
    trial     = {1'b0, rem, acc[DATA_W-1]} - {2'b00, den};
    qbit      = !trial[DATA_W+1];
    rem_next  = qbit ? trial[DATA_W-1:0] : {rem[DATA_W-2:0], acc[DATA_W-1]};
    abs_diff  = (acc >= prev_mean) ? (acc - prev_mean) : (prev_mean - acc);
    prod      = PROD_W'(corrected) * PROD_W'(COVER_FULL_SCALE);
    mean_prod = MPROD_W'(sum) * MPROD_W'(RECIP);
  end

  assign sample_ch.ready         = (state == ST_IDLE);
  assign result_ch.valid         = res_valid;
  assign result_ch.mean_value    = res_mean;
  assign result_ch.change_seen   = res_change;
  assign result_ch.cover_percent = res_cover;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_counts     <= '0;
      full_cover_counts <= '0;
      change_threshold  <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET:     offset_counts     <= cfg_data;
        CFG_FULL_COVER: full_cover_counts <= cfg_data;
        CFG_THRESHOLD:  change_threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      res_valid    <= 1'b0;
      sum          <= '0;
      prev_mean    <= '0;
      change_latch <= 1'b0;
      for (int k = 0; k < WINDOW_LEN; k++) begin
        window[k] <= '0;
      end
    end else begin
      // ST_FINISH reloads the output register itself
      if (res_valid && result_ch.ready && state != ST_FINISH) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample_ch.valid) begin
            for (int k = 0; k < WINDOW_LEN - 1; k++) begin
              window[k] <= window[k+1];
            end
            window[WINDOW_LEN-1] <= sample_ch.sample;
            sum <= sum - SUM_W'(window[0]) + SUM_W'(sample_ch.sample);
            state <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          acc   <= mean_prod[RECIP_SHIFT +: DATA_W];
          state <= ST_MEAN_DONE;
        end
        ST_MEAN_DONE: begin
          // acc now holds the mean
          if (abs_diff > change_threshold) begin
            change_latch <= 1'b1;
          end
          prev_mean <= acc;
          corrected <= (acc > offset_counts) ? (acc - offset_counts) : '0;
          state     <= ST_SCALE;
        end
        ST_SCALE: begin
          // also covers a zero full-cover count
          if (corrected >= full_cover_counts) begin
            cover_val <= COVER_FULL_SCALE;
            state     <= ST_FINISH;
          end else begin
            rem   <= prod[PROD_W-1:PCT_W];
            acc   <= {prod[PCT_W-1:0], (DATA_W-PCT_W)'(0)};
            den   <= full_cover_counts;
            cnt   <= CNT_W'(PCT_W - 1);
            state <= ST_COVER_DIV;
          end
        end
        ST_COVER_DIV: begin
          rem <= rem_next;
          acc <= {acc[DATA_W-2:0], qbit};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            cover_val <= {acc[PCT_W-2:0], qbit};
            state     <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!res_valid || result_ch.ready) begin
            res_valid  <= 1'b1;
            res_mean   <= prev_mean;
            res_change <= change_latch;
            res_cover  <= cover_val;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cover_range: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid |-> (result_ch.cover_percent <= COVER_FULL_SCALE))
    else $error("cover percent above full scale");

  a_latch_sticky: assert property (@(posedge clk) disable iff (rst)
    change_latch |=> change_latch)
    else $error("change latch cleared without reset");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (sample_ch.valid && sample_ch.ready) |=> !sample_ch.ready)
    else $error("item accepted while previous item in progress");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COVER_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");

endmodule

// ===== dv/proximity_average_cover_check.sv =====
`timescale 1ns / 1ps

module proximity_average_cover_check import pac_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  input  logic                 sample_ready,
  input  logic [DATA_W-1:0]    sample,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  logic [DATA_W-1:0]    mean_value,
  input  logic                 change_seen,
  input  logic [PCT_W-1:0]     cover_percent,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   mismatch_count,
  output int                   pending_results
);

  typedef struct packed {
    logic [DATA_W-1:0] mean_value;
    logic              change_seen;
    logic [PCT_W-1:0]  cover_percent;
  } avg_result_t;

  logic [DATA_W-1:0] window_q [WINDOW_LEN];
  logic [DATA_W-1:0] last_mean;
  logic              change_latch;
  logic [DATA_W-1:0] offset_reg;
  logic [DATA_W-1:0] full_cover_reg;
  logic [DATA_W-1:0] threshold_reg;

  avg_result_t expected_results [$];
  avg_result_t wanted;
  avg_result_t got;
  int          mismatches = 0;

  // Shift in one reading and work out mean, sticky change flag and cover.
  function automatic avg_result_t predict_reading(input logic [DATA_W-1:0] reading);
    int unsigned sum;
    int unsigned mean;
    int unsigned diff;
    int unsigned corrected;
    int unsigned pct;
    avg_result_t res;
    sum = 0;
    for (int k = 0; k < WINDOW_LEN - 1; k++) window_q[k] = window_q[k+1];
    window_q[WINDOW_LEN-1] = reading;
    for (int k = 0; k < WINDOW_LEN; k++) sum += window_q[k];
    mean = sum / WINDOW_LEN;
    diff = (mean >= last_mean) ? mean - last_mean : last_mean - mean;
    if (diff > threshold_reg) change_latch = 1'b1;
    last_mean = mean[DATA_W-1:0];
    if (full_cover_reg == 0) begin
      pct = COVER_FULL_SCALE;
    end else begin
      corrected = (mean > offset_reg) ? mean - offset_reg : 0;
      pct = (corrected * COVER_FULL_SCALE) / full_cover_reg;
      if (pct > COVER_FULL_SCALE) pct = COVER_FULL_SCALE;
    end
    res.mean_value    = mean[DATA_W-1:0];
    res.change_seen   = change_latch;
    res.cover_percent = pct[PCT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW_LEN; k++) window_q[k] = '0;
      last_mean      = '0;
      change_latch   = 1'b0;
      offset_reg     = '0;
      full_cover_reg = '0;
      threshold_reg  = THRESHOLD_RESET;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OFFSET:     offset_reg     = cfg_data;
          CFG_FULL_COVER: full_cover_reg = cfg_data;
          CFG_THRESHOLD:  threshold_reg  = cfg_data;
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        got.mean_value    = mean_value;
        got.change_seen   = change_seen;
        got.cover_percent = cover_percent;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: mean %0d change %0b cover %0d",
                     got.mean_value, got.change_seen, got.cover_percent);
        end else begin
          wanted = expected_results.pop_front();
          if (got !== wanted) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch at %0t: expected mean %0d change %0b cover %0d,",
                        " got mean %0d change %0b cover %0d"},
                       $realtime, wanted.mean_value, wanted.change_seen,
                       wanted.cover_percent, got.mean_value, got.change_seen,
                       got.cover_percent);
          end
        end
      end
      if (sample_valid && sample_ready) expected_results.push_back(predict_reading(sample));
    end
    mismatch_count  <= mismatches;
    pending_results <= expected_results.size();
  end

endmodule

// ===== dv/proximity_average_cover_test.sv =====
`timescale 1ns / 1ps

module proximity_average_cover_test;
  import pac_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES    = 30;
  localparam int END_CYCLES       = 40;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int SEGMENTS         = 8;
  localparam int SEGMENT_ITEMS    = 66;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;
  int                   mismatch_count;
  int                   pending_results;

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  bit long_hold       = 1'b0;
  int idle_cycles     = 0;

  pac_sample_if sample_ch ();
  pac_result_if result_ch ();

  proximity_average_cover #(.WINDOW_LEN(WINDOW_LEN_DEFAULT)) uut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  proximity_average_cover_check #(.WINDOW_LEN(WINDOW_LEN_DEFAULT)) u_check (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_ch.valid),
    .sample_ready    (sample_ch.ready),
    .sample          (sample_ch.sample),
    .result_valid    (result_ch.valid),
    .result_ready    (result_ch.ready),
    .mean_value      (result_ch.mean_value),
    .change_seen     (result_ch.change_seen),
    .cover_percent   (result_ch.cover_percent),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_reading(input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Drain all results, let the block settle, then write the registers.
  task automatic load_settings(input logic [DATA_W-1:0] offset, input logic [DATA_W-1:0] full,
                               input logic [DATA_W-1:0] thresh, input bit poke_unused);
    sample_ch.valid <= 1'b0;
    wait (pending_results == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_data  <= 16'hFFFF;
      @(negedge clk);
    end
    cfg_index <= CFG_OFFSET;
    cfg_data  <= offset;
    @(negedge clk);
    cfg_index <= CFG_FULL_COVER;
    cfg_data  <= full;
    @(negedge clk);
    cfg_index <= CFG_THRESHOLD;
    cfg_data  <= thresh;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly readings around the cover band, plus uniform, rail and small-step items.
  function automatic logic [DATA_W-1:0] pick_reading(input logic [DATA_W-1:0] offset,
                                                     input logic [DATA_W-1:0] full,
                                                     input logic [DATA_W-1:0] last);
    int choice;
    int span;
    int value;
    choice = $urandom_range(99);
    if (choice < 15) begin
      value = $urandom_range(65535);
    end else if (choice < 70) begin
      span  = full + full / 4 + 2;
      value = offset + $urandom_range(span) - 1;
    end else if (choice < 80) begin
      value = $urandom_range(1) ? 65535 : 0;
    end else begin
      value = last + $urandom_range(80) - 40;
    end
    if (value > 65535) value = 65535;
    if (value < 0) value = 0;
    return value[DATA_W-1:0];
  endfunction

  // Receiver side: random stalls, or one long hold-off when asked.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [DATA_W-1:0] off;
    logic [DATA_W-1:0] full;
    logic [DATA_W-1:0] thr;
    logic [DATA_W-1:0] reading;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_OFFSET;
    cfg_data         <= '0;
    sample_ch.valid  <= 1'b0;
    sample_ch.sample <= '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: full cover zero, threshold 30. Window starts at zeros.
    // Mean steps of exactly 30 must not set the flag, 31 must.
    send_reading(16'd0);
    send_reading(16'd120);
    send_reading(16'd120);
    send_reading(16'd124);
    repeat (4) send_reading(16'hFFFF);
    send_reading(16'd0);

    // Mean at or below offset gives zero cover; unused index is ignored.
    load_settings(16'hFFFF, 16'd1, 16'd0, 1'b1);
    repeat (3) send_reading(16'hFFFF);

    load_settings(16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    send_reading(16'hFFFF);
    send_reading(16'd0);

    // One count above offset with full cover of one saturates; at offset is zero.
    load_settings(16'd1000, 16'd1, 16'd30, 1'b0);
    repeat (4) send_reading(16'd1001);
    repeat (4) send_reading(16'd1000);

    reading = 16'd1000;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(3))
        0: off = '0;
        1: off = 16'hFFFF;
        2: off = DATA_W'($urandom_range(2000));
        default: off = DATA_W'($urandom_range(65535));
      endcase
      case ($urandom_range(4))
        0: full = '0;
        1: full = 16'd1;
        2: full = 16'hFFFF;
        3: full = DATA_W'($urandom_range(3000, 1));
        default: full = DATA_W'($urandom_range(65535));
      endcase
      case ($urandom_range(2))
        0: thr = '0;
        1: thr = 16'hFFFF;
        default: thr = DATA_W'($urandom_range(65535));
      endcase
      load_settings(off, full, thr, seg == 3);
      case (seg / 2)
        0: begin
          sender_idle_pct = 0;
          stall_pct       = 0;
        end
        1: begin
          sender_idle_pct = 69;
          stall_pct       = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct       = 69;
        end
        default: begin
          sender_idle_pct = 17;
          stall_pct       = 17;
        end
      endcase
      // Long receiver hold-off while items keep coming: block backs up.
      if (seg == 0) long_hold = 1'b1;
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        reading = pick_reading(off, full, reading);
        send_reading(reading);
      end
    end

    sample_ch.valid <= 1'b0;
    wait (pending_results == 0);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
